[src/swsd_pkg.sv]
// ----------------------------------------------------------------------------
// swsd_pkg
// Shared types and constants for the sliding window standard deviation block.
// ----------------------------------------------------------------------------
package swsd_pkg;

    localparam int NUM_WINDOWS = 4;
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;

    // field widths fixed by the interface
    localparam int WIN_BITS  = 2;
    localparam int XIN_BITS  = 16;
    localparam int CFG_BITS  = 7;
    localparam int OUT_BITS  = 24;

    // derived widths
    localparam int IDX_BITS  = $clog2(WINDOW_MAX);
    localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_BITS = WIN_BITS + IDX_BITS;
    localparam int DEPTH     = (1 << ADDR_BITS);
    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int S1_BITS   = SAMPLE_BITS + IDX_BITS + 1;
    localparam int S2_BITS   = SQ_BITS + IDX_BITS + 1;
    localparam int D_BITS    = LEN_BITS + S2_BITS;
    localparam int FRAC_SH   = 16;
    localparam int NUM_BITS  = D_BITS + FRAC_SH;
    localparam int DEN_BITS  = 2 * LEN_BITS;
    localparam int ROOT_BITS = (NUM_BITS + 1) / 2;
    localparam int RAD_BITS  = 2 * ROOT_BITS;

    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_SUB,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } swsd_state_t;

endpackage

[src/swsd_ifs.sv]
// ----------------------------------------------------------------------------
// swsd_ifs
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface swsd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  window_index;
    logic [15:0] sample;

    modport source (output valid, window_index, sample, input ready);
    modport sink   (input valid, window_index, sample, output ready);
endinterface

interface swsd_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] std_dev;
    logic        ready_res;

    modport source (output valid, std_dev, ready_res, input ready);
    modport sink   (input valid, std_dev, ready_res, output ready);
endinterface

[src/swsd_ram.sv]
// ----------------------------------------------------------------------------
// swsd_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swsd_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/swsd_div.sv]
// ----------------------------------------------------------------------------
// swsd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swsd_div
    import swsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quo
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [NUM_BITS-1:0] q_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS:0]   rem_sh;
    logic                fits;

    // trial subtract of one step
    assign rem_sh = {rem_reg, q_reg[NUM_BITS-1]};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_BITS-2:0], fits};
            rem_reg <= fits ? DEN_BITS'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_BITS-1:0];
        end
    end

    assign quo = q_reg;

endmodule

[src/swsd_sqrt.sv]
// ----------------------------------------------------------------------------
// swsd_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module swsd_sqrt
    import swsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_BITS-1:0]  rad,
    output logic                 done,
    output logic [ROOT_BITS-1:0] root
);

    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

    logic                 busy_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [RAD_BITS-1:0]  val_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS+1:0] rem_reg;
    logic [ROOT_BITS+1:0] rem_sh;
    logic [ROOT_BITS+1:0] trial;
    logic                 fits;

    assign rem_sh = {rem_reg[ROOT_BITS-1:0], val_reg[RAD_BITS-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(ROOT_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // one root digit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= RAD_BITS'(rad);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[RAD_BITS-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
        end
    end

    assign root = root_reg;

endmodule

[src/sliding_window_std_deviation_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_std_deviation_top
// Per-window sample standard deviation over a ring of stored samples.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                      Handshake
// samples   in   window_index[2], sample[16]  valid/ready
// results   out  std_dev[24], ready_res[1]    valid/ready
// cfg       in   cfg_data[7] (window_len)     cfg_we, no wait
//
// One word at a time. A word on a full window reads all N samples of the window
// from RAM, then runs the divider steps and then the square root steps; other
// words go straight to the final state. Reset clears positions and full flags;
// the RAM is not cleared. The output register lets the next sample be taken
// while a result waits; a second result holds the sequencer in its final state
// until the first one is taken.
// ----------------------------------------------------------------------------
module sliding_window_std_deviation_top
    import swsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    swsd_in_if.sink             samples,
    swsd_out_if.source          results,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data
);

    swsd_state_t state_reg, state_next;

    logic [CFG_BITS-1:0]  wlen_reg;
    logic [LEN_BITS-1:0]  wpos_reg [NUM_WINDOWS];
    logic                 wfull_reg [NUM_WINDOWS];
    logic [LEN_BITS-1:0]  len_reg;
    logic [WIN_BITS-1:0]  win_reg;
    logic [LEN_BITS-1:0]  rd_cnt_reg;
    logic                 v1_reg, v2_reg;
    logic [SAMPLE_BITS-1:0] dat_reg;
    logic [SQ_BITS-1:0]   sq_reg;
    logic [S1_BITS-1:0]   s1_reg;
    logic [S2_BITS-1:0]   s2_reg;
    logic [D_BITS-1:0]    pa_reg, pb_reg;
    logic [DEN_BITS-1:0]  den_reg;
    logic [OUT_BITS-1:0]  res_reg;
    logic                 rdy_reg;
    logic                 out_valid_reg;
    logic [OUT_BITS-1:0]  out_dev_reg;
    logic                 out_rdy_reg;

    logic                 accept, win_ok, len_ok, wrap, issue, sum_end, load_out;
    logic [LEN_BITS-1:0]  len_eff, pos_old, pos_new;
    logic [SAMPLE_BITS-1:0] x_in, rdata;
    logic [ADDR_BITS-1:0] raddr, waddr;
    logic                 div_start, div_done, sq_start, sq_done;
    logic [NUM_BITS-1:0]  div_num, quo;
    logic [ROOT_BITS-1:0] root;

    // accept decode and ring pointer update
    assign accept  = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);
    assign len_eff = (int'(wlen_reg) > WINDOW_MAX) ? LEN_BITS'(WINDOW_MAX)
                                                   : LEN_BITS'(wlen_reg);
    assign win_ok  = (int'(samples.window_index) < NUM_WINDOWS);
    assign len_ok  = (len_eff >= LEN_BITS'(2));
    assign pos_old = wpos_reg[samples.window_index];
    assign wrap    = (pos_old >= len_eff);
    assign pos_new = wrap ? '0 : pos_old;
    assign x_in    = SAMPLE_BITS'(samples.sample);
    assign waddr   = {samples.window_index, pos_new[IDX_BITS-1:0]};
    assign raddr   = {win_reg, rd_cnt_reg[IDX_BITS-1:0]};
    assign issue   = (state_reg == ST_SUM) && (rd_cnt_reg < len_reg);
    assign sum_end = (rd_cnt_reg == len_reg) && !v1_reg && !v2_reg;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    swsd_ram #(
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (accept && win_ok && len_ok),
        .waddr (waddr),
        .wdata (x_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign div_start = (state_reg == ST_SUB);
    assign div_num   = {D_BITS'(pa_reg - pb_reg), FRAC_SH'(0)};
    assign sq_start  = (state_reg == ST_DIV) && div_done;

    swsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quo   (quo)
    );

    swsd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (quo),
        .done  (sq_done),
        .root  (root)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (win_ok && len_ok && (wrap || wfull_reg[samples.window_index]))
                        state_next = ST_SUM;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SUM:  if (sum_end) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_SQRT;
            ST_SQRT: if (sq_done) state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= CFG_BITS'(8);
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            for (int i = 0; i < NUM_WINDOWS; i++)
            begin
                wpos_reg[i]  <= '0;
                wfull_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (cfg_we)
                wlen_reg <= cfg_data;
            if (accept && win_ok && len_ok)
            begin
                wpos_reg[samples.window_index] <= pos_new + 1'b1;
                if (wrap)
                    wfull_reg[samples.window_index] <= 1'b1;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // window walk, products and result
    always_ff @(posedge clk)
    begin
        dat_reg <= rdata;
        sq_reg  <= rdata * rdata;
        if (accept)
        begin
            len_reg    <= len_eff;
            win_reg    <= samples.window_index;
            rd_cnt_reg <= '0;
            s1_reg     <= '0;
            s2_reg     <= '0;
            res_reg    <= '0;
            rdy_reg    <= 1'b0;
        end
        if (issue)
            rd_cnt_reg <= rd_cnt_reg + 1'b1;
        if (v2_reg)
        begin
            s1_reg <= s1_reg + S1_BITS'(dat_reg);
            s2_reg <= s2_reg + S2_BITS'(sq_reg);
        end
        if (state_reg == ST_MUL)
        begin
            pa_reg  <= len_reg * s2_reg;
            pb_reg  <= D_BITS'(s1_reg * s1_reg);
            den_reg <= len_reg * (len_reg - 1'b1);
        end
        if ((state_reg == ST_SQRT) && sq_done)
        begin
            res_reg <= (root > ROOT_BITS'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(root);
            rdy_reg <= 1'b1;
        end
        if (load_out)
        begin
            out_dev_reg <= res_reg;
            out_rdy_reg <= rdy_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.std_dev   = out_dev_reg;
    assign results.ready_res = out_rdy_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after accepting a word");

    a_zero_when_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready_res) |-> (results.std_dev == '0))
        else $error("nonzero deviation on a not-ready result");

    a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (len_reg >= LEN_BITS'(2) && rd_cnt_reg <= len_reg))
        else $error("window walk out of range");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

endmodule

[verif/swsd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swsd_checker
// Watches the sample, result and config ports of the window deviation block.
// Keeps its own copy of the sample rings and positions, predicts one result
// word per accepted sample word, and compares it with the next result word.
// ----------------------------------------------------------------------------
module swsd_checker
    import swsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    swsd_in_if                  samples,
    swsd_out_if                 results,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data,
    output int                  fail_count,
    output int                  pending,
    output int                  valid_seen
);

    typedef struct packed {
        logic [OUT_BITS-1:0] std_dev;
        logic                ready_res;
    } dev_word_t;

    // mirrored block state
    logic [XIN_BITS-1:0] ring [NUM_WINDOWS][WINDOW_MAX];
    int unsigned         wr_pos [NUM_WINDOWS];
    logic                filled [NUM_WINDOWS];
    logic [CFG_BITS-1:0] win_len;
    dev_word_t           dev_queue [$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // store the sample when the window length is at least two, and work out the deviation of the window
    function automatic dev_word_t window_deviation(int unsigned w, logic [XIN_BITS-1:0] x);
        dev_word_t       r;
        int unsigned     n;
        int unsigned     p;
        longint unsigned s1;
        longint unsigned s2;
        logic [127:0]    num;
        logic [127:0]    quo;
        longint unsigned root;
        r  = '0;
        n  = (win_len > WINDOW_MAX) ? WINDOW_MAX : win_len;
        s1 = 0;
        s2 = 0;
        if (n < 2)
            return r;
        p = wr_pos[w];
        if (p >= n)
        begin
            p         = 0;
            filled[w] = 1'b1;
        end
        ring[w][p] = x;
        wr_pos[w]  = p + 1;
        if (!filled[w])
            return r;
        for (int i = 0; i < n; i++)
        begin
            s1 += ring[w][i];
            s2 += longint'(ring[w][i]) * ring[w][i];
        end
        num = (128'(n) * s2 - 128'(s1) * s1) << 16;
        quo = num / (128'(n) * (n - 1));
        if (quo[127:64] != 0)
            root = OUT_MAX;
        else
        begin
            root = int_sqrt(quo[63:0]);
            if (root > OUT_MAX)
                root = OUT_MAX;
        end
        r.std_dev   = root[OUT_BITS-1:0];
        r.ready_res = 1'b1;
        return r;
    endfunction

    assign pending = dev_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        dev_word_t exp_w;
        if (!rst_n)
        begin
            win_len    <= 7'd8;
            fail_count <= 0;
            valid_seen <= 0;
            dev_queue.delete();
            for (int w = 0; w < NUM_WINDOWS; w++)
            begin
                wr_pos[w] = 0;
                filled[w] = 1'b0;
            end
        end
        else
        begin
            // compare the result word against the oldest prediction
            if (results.valid && results.ready)
            begin
                if (dev_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result word with nothing expected: std_dev=%0d rdy=%0b",
                                 $realtime, results.std_dev, results.ready_res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = dev_queue.pop_front();
                    if (exp_w.ready_res)
                        valid_seen <= valid_seen + 1;
                    if (exp_w.std_dev !== results.std_dev ||
                        exp_w.ready_res !== results.ready_res)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: std_dev exp %0d got %0d, rdy exp %0b got %0b",
                                     $realtime, exp_w.std_dev, results.std_dev,
                                     exp_w.ready_res, results.ready_res);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // predict from each accepted sample word
            if (samples.valid && samples.ready)
                dev_queue.push_back(window_deviation(samples.window_index, samples.sample));
            if (cfg_we)
                win_len <= cfg_data;
        end
    end

endmodule

[verif/sliding_window_std_deviation_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_std_deviation_top_tb
// Drives sample words through several window lengths, from the short-window
// case up past the saturation limit and down again, with random gaps and
// result back-pressure. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sliding_window_std_deviation_top_tb;
    import swsd_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_data;
    logic                calm;
    int                  fail_count;
    int                  pending;
    int                  valid_seen;
    int                  words_sent;

    swsd_in_if  samples ();
    swsd_out_if results ();

    sliding_window_std_deviation_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .results  (results),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    swsd_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .results    (results),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .valid_seen (valid_seen)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure
    initial
    begin
        int n;
        results.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                results.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            results.ready <= 1'b1;
            do @(posedge clk); while (!results.valid);
        end
    end

    task automatic send_word(int unsigned w, logic [15:0] x);
        int n;
        n = calm ? 0 : $urandom_range(0, 3);
        if (n > 0)
        begin
            samples.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        samples.valid        <= 1'b1;
        samples.window_index <= w[1:0];
        samples.sample       <= x;
        do @(posedge clk); while (!samples.ready);
        words_sent++;
    endtask

    // wait for all results, then write window_len
    task automatic set_window_len(logic [CFG_BITS-1:0] v);
        samples.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample(logic [15:0] base);
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return base + 16'($urandom_range(0, 15));
            3: return base ^ 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    // fill every window in order, then random words
    task automatic run_phase(logic [CFG_BITS-1:0] len, int count);
        int          n;
        logic [15:0] base;
        set_window_len(len);
        calm = ($urandom_range(0, 3) == 0);
        n    = (len > WINDOW_MAX) ? WINDOW_MAX : len;
        base = 16'($urandom());
        for (int w = 0; w < NUM_WINDOWS; w++)
            for (int i = 0; i < n; i++)
                send_word(w, pick_sample(base));
        for (int k = 0; k < count; k++)
        begin
            if (k % 64 == 63)
            begin
                calm = ($urandom_range(0, 3) == 0);
                base = 16'($urandom());
            end
            send_word($urandom_range(0, NUM_WINDOWS - 1), pick_sample(base));
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        calm                 = 1'b0;
        words_sent           = 0;
        samples.valid        = 1'b0;
        samples.window_index = '0;
        samples.sample       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short window: nothing stored, every result zero
        set_window_len(7'd1);
        send_word(0, 16'h0000);
        send_word(1, 16'hFFFF);
        send_word(2, 16'h5555);
        send_word(3, 16'hAAAA);

        // length above the limit saturates; largest windows
        run_phase(7'd127, 120);
        // middle lengths, then extremes and constant windows on a two-sample window
        run_phase(7'd64, 120);
        run_phase(7'd13, 300);
        run_phase(7'd3, 500);
        set_window_len(7'd2);
        send_word(0, 16'h0000);
        send_word(0, 16'hFFFF);
        send_word(0, 16'hFFFF);
        send_word(0, 16'hFFFF);
        send_word(0, 16'h0000);
        send_word(0, 16'h0000);
        send_word(1, 16'h0001);
        send_word(1, 16'h0000);
        send_word(1, 16'h0000);
        run_phase(7'd2, 310);

        samples.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Sent %0d sample words over window lengths 1, 127, 64, 13, 3, 2;",
                 words_sent);
        $display("%0d full-window deviations checked, %0d mismatches.",
                 valid_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule
